// File: rtl/display_unit_frame_responder_core_macros.svh
`ifndef DISPLAY_UNIT_FRAME_RESPONDER_CORE_MACROS_SVH
`define DISPLAY_UNIT_FRAME_RESPONDER_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define DUFR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DUFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/dufr_pkg.sv
package dufr_pkg;

  localparam int RX_FRAME_LEN   = 6;
  localparam int TX_FRAME_LEN   = 10;
  localparam int PANEL_LEN      = 4;
  localparam int MAX_RUN        = RX_FRAME_LEN + TX_FRAME_LEN;
  localparam int RUN_CNT_W      = $clog2(MAX_RUN);
  localparam int RUN_LEN_W      = $clog2(MAX_RUN + 1);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int JOBQ_DEPTH_DEF = 2;

  localparam logic [15:0] REPLY_DELAY_RST = 16'd300;
  localparam logic [7:0]  BYTE_GAP_RST    = 8'd2;

  localparam int ECHO_BYTE = 4;
  localparam int ECHO_BIT  = 7;
  localparam int CMD_BYTE  = 5;
  localparam int R_BIT     = 1;
  localparam int I_BIT     = 0;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TICK    = 2'd1,
    OP_PANEL   = 2'd2
  } dufr_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_ON   = 3'd0,
    REG_REQUEST    = 3'd1,
    REG_INFO       = 3'd2,
    REG_NORMAL     = 3'd3,
    REG_REPLY_DLY  = 3'd4,
    REG_BYTE_GAP   = 3'd5
  } dufr_reg_e;

  // One unit of transmit work: an optional echo run followed by an optional
  // status frame. Status bytes 6..9 are always zero and are not carried.
  typedef struct packed {
    logic                               echo;
    logic                               status;
    logic [RX_FRAME_LEN-1:0][7:0]       echo_bytes;
    logic [PANEL_LEN+1:0][7:0]          stat_bytes;
  } dufr_job_t;

endpackage

// File: rtl/display_unit_frame_responder_core.sv
// An item's job goes into the job queue; the first word of its run then moves into the
// output register. One item per cycle is taken while the queue is not full; the back
// end sends one word per cycle while the result port is free or popped; a run holds
// 6, 10 or 16 words. A job queue of JobqDepth entries lets the input side run ahead of
// the sender. Reset is asynchronous, active low: timers, counters, config to defaults.
module display_unit_frame_responder_core import dufr_pkg::*; #(
  parameter int JobqDepth = JOBQ_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            op_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [1:0]            panel_index_i,
  input  logic [7:0]            panel_value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            tx_byte_o,
  output logic                  frame_kind_o,
  output logic                  last_of_run_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic      take, job_valid, q_empty, job_pop;
  dufr_job_t job_in, job_head;

  assign take = push && !full;

  dufr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .op_i          (op_i),
    .rx_byte_i     (rx_byte_i),
    .panel_index_i (panel_index_i),
    .panel_value_i (panel_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .job_valid_o   (job_valid),
    .job_o         (job_in)
  );

  dufr_jobq #(.Depth(JobqDepth)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .rdata_o (job_head)
  );

  dufr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .tx_byte_o     (tx_byte_o),
    .frame_kind_o  (frame_kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: rtl/dufr_front.sv
module dufr_front import dufr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [1:0]            op_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [1:0]            panel_index_i,
  input  logic [7:0]            panel_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  job_valid_o,
  output dufr_job_t             job_o
);

  localparam logic [2:0] RxLast = 3'(RX_FRAME_LEN - 1);

  logic [15:0] power_on_q, power_on_d, request_q, request_d, info_q, info_d;
  logic [15:0] normal_q, normal_d, delay_q, delay_d;
  logic [7:0]  gap_ticks_q, gap_ticks_d;

  logic [PANEL_LEN-1:0][7:0]    panel_q, panel_d;
  logic [1:0][7:0]              pair_q, pair_d;
  logic [RX_FRAME_LEN-1:0][7:0] frame_q, frame_d;
  logic [2:0]  rx_cnt_q, rx_cnt_d;
  logic        gap_on_q, gap_on_d;
  logic [7:0]  gap_cnt_q, gap_cnt_d;
  logic        reply_on_q, reply_on_d;
  logic [15:0] reply_cnt_q, reply_cnt_d;
  logic        first_done_q, first_done_d;

  logic        echo, status;
  logic [15:0] reply_dec;
  logic [7:0]  gap_dec;

  // Configuration writes; indexes past the list are ignored.
  always_comb begin
    power_on_d  = power_on_q;
    request_d   = request_q;
    info_d      = info_q;
    normal_d    = normal_q;
    delay_d     = delay_q;
    gap_ticks_d = gap_ticks_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POWER_ON:  power_on_d  = cfg_wdata_i;
        REG_REQUEST:   request_d   = cfg_wdata_i;
        REG_INFO:      info_d      = cfg_wdata_i;
        REG_NORMAL:    normal_d    = cfg_wdata_i;
        REG_REPLY_DLY: delay_d     = cfg_wdata_i;
        REG_BYTE_GAP:  gap_ticks_d = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign reply_dec = (reply_cnt_q != '0) ? reply_cnt_q - 16'd1 : reply_cnt_q;
  assign gap_dec   = (gap_cnt_q != '0) ? gap_cnt_q - 8'd1 : gap_cnt_q;

  always_comb begin
    panel_d      = panel_q;
    pair_d       = pair_q;
    frame_d      = frame_q;
    rx_cnt_d     = rx_cnt_q;
    gap_on_d     = gap_on_q;
    gap_cnt_d    = gap_cnt_q;
    reply_on_d   = reply_on_q;
    reply_cnt_d  = reply_cnt_q;
    first_done_d = first_done_q;
    echo         = 1'b0;
    status       = 1'b0;
    if (take_i) begin
      case (op_i)
        OP_RX_BYTE: begin
          frame_d[rx_cnt_q] = rx_byte_i;
          if (rx_cnt_q == RxLast) begin
            gap_on_d = 1'b0;
            rx_cnt_d = '0;
            if (!first_done_q) begin
              pair_d       = power_on_q;
              first_done_d = 1'b1;
              status       = 1'b1;
            end else begin
              echo = frame_q[ECHO_BYTE][ECHO_BIT];
              if (rx_byte_i[R_BIT] || rx_byte_i[I_BIT]) begin
                reply_cnt_d = delay_q;
                reply_on_d  = 1'b1;
              end
              // The normal word wins over the R word when the I bit is clear.
              if (rx_byte_i[I_BIT]) begin
                pair_d = info_q;
              end else begin
                pair_d = normal_q;
                status = 1'b1;
              end
            end
          end else begin
            rx_cnt_d  = rx_cnt_q + 3'd1;
            gap_cnt_d = gap_ticks_q;
            gap_on_d  = 1'b1;
          end
        end
        OP_TICK: begin
          if (reply_on_q) begin
            reply_cnt_d = reply_dec;
            if (reply_dec == '0) begin
              reply_on_d = 1'b0;
              status     = 1'b1;
            end
          end
          if (gap_on_q) begin
            gap_cnt_d = gap_dec;
            if (gap_dec == '0) begin
              gap_on_d = 1'b0;
              rx_cnt_d = '0;
            end
          end
        end
        OP_PANEL: panel_d[panel_index_i] = panel_value_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    job_o.echo   = echo;
    job_o.status = status;
    for (int i = 0; i < RX_FRAME_LEN - 1; i++) begin
      job_o.echo_bytes[i] = frame_q[i];
    end
    job_o.echo_bytes[RX_FRAME_LEN-1] = rx_byte_i;
    for (int i = 0; i < PANEL_LEN; i++) begin
      job_o.stat_bytes[i] = panel_q[i];
    end
    job_o.stat_bytes[PANEL_LEN]   = pair_d[1];
    job_o.stat_bytes[PANEL_LEN+1] = pair_d[0];
  end

  assign job_valid_o = take_i && (echo || status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_on_q   <= '0;
      request_q    <= '0;
      info_q       <= '0;
      normal_q     <= '0;
      delay_q      <= REPLY_DELAY_RST;
      gap_ticks_q  <= BYTE_GAP_RST;
      panel_q      <= '0;
      pair_q       <= '0;
      rx_cnt_q     <= '0;
      gap_on_q     <= 1'b0;
      gap_cnt_q    <= '0;
      reply_on_q   <= 1'b0;
      reply_cnt_q  <= '0;
      first_done_q <= 1'b0;
    end else begin
      power_on_q   <= power_on_d;
      request_q    <= request_d;
      info_q       <= info_d;
      normal_q     <= normal_d;
      delay_q      <= delay_d;
      gap_ticks_q  <= gap_ticks_d;
      panel_q      <= panel_d;
      pair_q       <= pair_d;
      rx_cnt_q     <= rx_cnt_d;
      gap_on_q     <= gap_on_d;
      gap_cnt_q    <= gap_cnt_d;
      reply_on_q   <= reply_on_d;
      reply_cnt_q  <= reply_cnt_d;
      first_done_q <= first_done_d;
    end
  end

  // Frame bytes are always written before they are read.
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

// File: rtl/dufr_jobq.sv
module dufr_jobq import dufr_pkg::*; #(
  parameter int Depth = JOBQ_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dufr_job_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output dufr_job_t rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  dufr_job_t             mem_q [Depth];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/dufr_back.sv
module dufr_back import dufr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  dufr_job_t job_i,
  output logic      job_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output logic [7:0] tx_byte_o,
  output logic      frame_kind_o,
  output logic      last_of_run_o
);

  localparam logic [RUN_CNT_W-1:0] EchoLen = RUN_CNT_W'(RX_FRAME_LEN);

  logic [RUN_CNT_W-1:0] cnt_q, cnt_d, stat_idx;
  logic [RUN_LEN_W-1:0] run_len;
  logic                 in_echo, last, advance;
  logic [7:0]           byte_sel;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           tx_byte_q;
  logic                 kind_q, last_q;

  assign run_len = (job_i.echo   ? RUN_LEN_W'(RX_FRAME_LEN) : '0)
                 + (job_i.status ? RUN_LEN_W'(TX_FRAME_LEN) : '0);
  assign in_echo  = job_i.echo && (cnt_q < EchoLen);
  assign stat_idx = job_i.echo ? cnt_q - EchoLen : cnt_q;
  assign last     = ({1'b0, cnt_q} == run_len - RUN_LEN_W'(1));

  always_comb begin
    if (in_echo) begin
      byte_sel = job_i.echo_bytes[cnt_q[2:0]];
    end else if (stat_idx < RUN_CNT_W'(PANEL_LEN + 2)) begin
      byte_sel = job_i.stat_bytes[stat_idx[2:0]];
    end else begin
      byte_sel = 8'h00;
    end
  end

  // A new word moves into the output register when it is free or being taken.
  assign advance   = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = advance && last;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      cnt_d       = last ? '0 : cnt_q + RUN_CNT_W'(1);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tx_byte_q <= byte_sel;
      kind_q    <= !in_echo;
      last_q    <= last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign frame_kind_o  = kind_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/dufr_checker.sv
`include "display_unit_frame_responder_core_macros.svh"

module dufr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] tx_byte_o,
  input logic       frame_kind_o,
  input logic       last_of_run_o
);

  // A word that waits must stay put.
  `DUFR_ASSERT(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(tx_byte_o) && $stable(frame_kind_o) && $stable(last_of_run_o), "waiting word changed")

  // A status frame is never cut short: the next word shown continues it.
  `DUFR_ASSERT(a_status_run, clk_i, rst_ni, pop && !empty && frame_kind_o && !last_of_run_o ##1 !empty |-> frame_kind_o, "status frame interrupted")

  // During reset the output looks empty and the job queue is not full.
  `DUFR_ASSERT_ALWAYS(a_reset, clk_i, !rst_ni |-> empty && !full, "queue state wrong in reset")

endmodule

bind display_unit_frame_responder_core dufr_checker u_chk (.*);
